FILE: hw/rtl/height_to_normal_map_top_assert.svh
// Assertion macros shared by the normal map RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef HEIGHT_TO_NORMAL_MAP_TOP_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_TOP_ASSERT_SVH

// same-cycle implication
`define HNM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HNM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/hnm_pkg.sv
// Shared types and constants of the height to normal map block.
// No dependencies.
package hnm_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int CFG_WID_W  = 12;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int MAX_HEIGHT = 4096;

    localparam int NUM_W   = 30;
    localparam int S_W     = 18;
    localparam int SQ_W    = 16;
    localparam int RAD_W   = 15;
    localparam int CNT_W   = 5;
    localparam int DIV_STEPS  = NUM_W;
    localparam int ROOT_STEPS = 8;

    localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [NUM_W-1:0]     BLUE_NUM     = 30'd1065369600;
    localparam logic [S_W-1:0]       S_BIAS       = 18'd65025;
    localparam logic [7:0]           BIAS         = 8'd128;
    localparam logic [7:0]           ALPHA        = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [1:0] JOB_UP   = 2'd0;
    localparam logic [1:0] JOB_LEFT = 2'd1;
    localparam logic [1:0] JOB_LAST = 2'd2;

    localparam logic [1:0] PASS_BLUE  = 2'd0;
    localparam logic [1:0] PASS_RED   = 2'd1;
    localparam logic [1:0] PASS_GREEN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD_RIGHT, ST_WR, ST_JOB, ST_WAIT, ST_PUSH, ST_FINISH
    } t_seq_state;

    typedef enum logic [2:0] {
        NU_IDLE, NU_SETUP, NU_DIV, NU_SQRT, NU_DONE
    } t_nu_state;

    typedef struct packed {
        logic [7:0] height;
    } t_in_data;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [COL_W-1:0] out_column;
        logic [ROW_W-1:0] out_row;
        logic             last_of_run;
        logic             end_of_frame;
    } t_out_data;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_data;

    typedef struct packed {
        logic       start;
        logic [7:0] h;
        logic [7:0] right;
        logic [7:0] below;
    } t_norm_req;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_norm_rsp;

endpackage

FILE: hw/rtl/hnm_if.sv
// Valid/ready channel interfaces of the normal map block.
// Depends on hnm_pkg.
interface hnm_in_if;
    logic              valid;
    logic              ready;
    hnm_pkg::t_in_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hnm_out_if;
    logic               valid;
    logic               ready;
    hnm_pkg::t_out_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hnm_cfg_if;
    logic               valid;
    logic               ready;
    hnm_pkg::t_cfg_data data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/hnm_line_ram.sv
// Simple dual-port line RAM, one write and one registered read port.
// No dependencies.
module hnm_line_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/hnm_norm_unit.sv
// Bit-serial normal vector unit: restoring divider then digit root,
// three passes (blue, red, green). Depends on hnm_pkg.
module hnm_norm_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hnm_pkg::t_norm_req i_req,
    output hnm_pkg::t_norm_rsp o_rsp
);
    hnm_pkg::t_nu_state r_state, n_state;

    logic [7:0]              r_h, r_right, r_below;
    logic [hnm_pkg::S_W-1:0]   r_s;
    logic [hnm_pkg::SQ_W-1:0]  r_sqx, r_sqy;
    logic                      r_negx, r_negy;
    logic [1:0]                r_pass;
    logic [hnm_pkg::NUM_W-1:0] r_num;
    logic [hnm_pkg::S_W-1:0]   r_rem;
    logic [hnm_pkg::CNT_W-1:0] r_cnt;
    logic [hnm_pkg::RAD_W-1:0] r_v, r_root, r_bit;
    logic                      r_div_exact;
    logic [7:0]                r_red, r_green, r_blue;

    // setup arithmetic
    logic signed [8:0] dx, dy;
    logic [7:0]        mx, my;
    logic [hnm_pkg::SQ_W-1:0] sqx, sqy;
    logic [hnm_pkg::S_W-1:0]  s_sum;

    // divider step
    logic [hnm_pkg::S_W:0]     trial;
    logic                      qbit;
    logic [hnm_pkg::S_W-1:0]   n_rem;
    logic [hnm_pkg::NUM_W-1:0] n_num;

    // root step
    logic [hnm_pkg::RAD_W-1:0] rb, n_v, n_root;
    logic [7:0]                root8;
    logic                      exact, neg;
    logic [7:0]                signed_res;
    logic [8:0]                blue_sum;

    always_comb begin
        dx  = $signed({1'b0, r_h}) - $signed({1'b0, r_right});
        dy  = $signed({1'b0, r_h}) - $signed({1'b0, r_below});
        mx  = dx[8] ? 8'(-dx) : dx[7:0];
        my  = dy[8] ? 8'(-dy) : dy[7:0];
        sqx = mx * mx;
        sqy = my * my;
        s_sum = hnm_pkg::S_W'(sqx) + hnm_pkg::S_W'(sqy) + hnm_pkg::S_BIAS;

        trial = {r_rem, r_num[hnm_pkg::NUM_W-1]};
        qbit  = trial >= {1'b0, r_s};
        n_rem = qbit ? hnm_pkg::S_W'(trial - {1'b0, r_s})
                     : hnm_pkg::S_W'(trial);
        n_num = {r_num[hnm_pkg::NUM_W-2:0], qbit};

        rb = r_root + r_bit;
        if (r_v >= rb) begin
            n_v    = r_v - rb;
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_v    = r_v;
            n_root = r_root >> 1;
        end
        root8 = n_root[7:0];
        exact = r_div_exact && (n_v == '0);
        neg   = (r_pass == hnm_pkg::PASS_RED) ? r_negx : r_negy;
        // negative side rounds away from zero unless the root is exact
        signed_res = neg ? 8'(hnm_pkg::BIAS - root8 - {7'd0, !exact})
                         : 8'(hnm_pkg::BIAS + root8);
        blue_sum = {1'b0, hnm_pkg::BIAS} + {1'b0, root8};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hnm_pkg::NU_IDLE:  if (i_req.start) n_state = hnm_pkg::NU_SETUP;
            hnm_pkg::NU_SETUP: n_state = hnm_pkg::NU_DIV;
            hnm_pkg::NU_DIV: begin
                if (r_cnt == hnm_pkg::CNT_W'(hnm_pkg::DIV_STEPS - 1))
                    n_state = hnm_pkg::NU_SQRT;
            end
            hnm_pkg::NU_SQRT: begin
                if (r_cnt == hnm_pkg::CNT_W'(hnm_pkg::ROOT_STEPS - 1)) begin
                    n_state = (r_pass == hnm_pkg::PASS_GREEN) ? hnm_pkg::NU_DONE
                                                              : hnm_pkg::NU_DIV;
                end
            end
            hnm_pkg::NU_DONE:  n_state = hnm_pkg::NU_IDLE;
            default:           n_state = hnm_pkg::NU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnm_pkg::NU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hnm_pkg::NU_IDLE: begin
                r_h     <= i_req.h;
                r_right <= i_req.right;
                r_below <= i_req.below;
            end
            hnm_pkg::NU_SETUP: begin
                r_s    <= s_sum;
                r_sqx  <= sqx;
                r_sqy  <= sqy;
                r_negx <= dx[8];
                r_negy <= !dy[8] && (dy != 9'sd0);
                r_pass <= hnm_pkg::PASS_BLUE;
                r_num  <= hnm_pkg::BLUE_NUM;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            hnm_pkg::NU_DIV: begin
                r_num <= n_num;
                r_rem <= n_rem;
                if (r_cnt == hnm_pkg::CNT_W'(hnm_pkg::DIV_STEPS - 1)) begin
                    r_v         <= n_num[hnm_pkg::RAD_W-1:0];
                    r_root      <= '0;
                    r_bit       <= hnm_pkg::RAD_W'(1) << (hnm_pkg::RAD_W - 1);
                    r_div_exact <= (n_rem == '0);
                    r_cnt       <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            hnm_pkg::NU_SQRT: begin
                r_v    <= n_v;
                r_root <= n_root;
                r_bit  <= r_bit >> 2;
                if (r_cnt == hnm_pkg::CNT_W'(hnm_pkg::ROOT_STEPS - 1)) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    unique case (r_pass)
                        hnm_pkg::PASS_BLUE: begin
                            r_blue <= blue_sum[8] ? 8'hFF : blue_sum[7:0];
                            r_num  <= {r_sqx, 14'd0};
                            r_pass <= hnm_pkg::PASS_RED;
                        end
                        hnm_pkg::PASS_RED: begin
                            r_red  <= signed_res;
                            r_num  <= {r_sqy, 14'd0};
                            r_pass <= hnm_pkg::PASS_GREEN;
                        end
                        default: begin
                            r_green <= signed_res;
                        end
                    endcase
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.busy  = (r_state != hnm_pkg::NU_IDLE);
    assign o_rsp.done  = (r_state == hnm_pkg::NU_DONE);
    assign o_rsp.red   = r_red;
    assign o_rsp.green = r_green;
    assign o_rsp.blue  = r_blue;
endmodule

FILE: hw/rtl/height_to_normal_map_top.sv
// Height map to normal map converter, raster in, RGBA normals out.
// Depends on hnm_pkg, hnm_if, hnm_line_ram, hnm_norm_unit.
//
// Channels: i_in takes one 8-bit height per transaction in raster order;
// o_out gives normal pixels with their column/row and run/frame flags;
// i_cfg writes image_width (index 0) or image_height (index 1), which
// restarts the frame. Config must be written only while the block is idle;
// the block does not enforce it. Row y-1 is emitted as row y arrives; on
// the last row each height emits the pixel to its left, and its final height
// also flushes itself. Each height goes through accept, line store read/write
// and wrap-up, then for each result it causes (0 to 3) the shared normal
// unit runs a 30-step serial divider and an 8-step root for each of blue,
// red, green. One height is worked on at a time; i_in.ready is high only when
// idle. A result waits in the output register while o_out.ready is low; the
// next result is computed meanwhile and held until the register frees. Reset
// clears counters and config to 640 x 480; the line store is not cleared and
// needs no clearing pass, each entry is written before use.
module height_to_normal_map_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    hnm_in_if.sink  i_in,
    hnm_out_if.source o_out,
    hnm_cfg_if.sink i_cfg
);
    `include "height_to_normal_map_top_assert.svh"

    localparam int AW = hnm_pkg::ADDR_W;

    hnm_pkg::t_seq_state r_state, n_state;

    logic [AW-1:0]                 r_col;
    logic [hnm_pkg::ROW_W-1:0]     r_row;
    logic [7:0]                    r_left, r_h, r_up, r_right;
    logic [2:0]                    r_mask, n_mask;
    logic [1:0]                    r_cur, sel;
    logic                          r_cur_last;
    logic [hnm_pkg::CFG_WID_W-1:0] r_w;
    logic [hnm_pkg::CFG_HGT_W-1:0] r_hgt;
    hnm_pkg::t_out_data            r_out;
    logic                          r_out_valid;

    logic [AW-1:0]             w_m1, ram_raddr;
    logic [hnm_pkg::ROW_W-1:0] h_m1;
    logic                      last_col, last_row;
    logic [7:0]                ram_rdata;
    logic                      in_acc, cfg_acc, out_load;
    hnm_pkg::t_norm_req        req;
    hnm_pkg::t_norm_rsp        rsp;

    // clamp the frame size
    always_comb begin
        if (r_w == '0)
            w_m1 = '0;
        else if (r_w > hnm_pkg::CFG_WID_W'(hnm_pkg::MAX_WIDTH))
            w_m1 = AW'(hnm_pkg::MAX_WIDTH - 1);
        else
            w_m1 = AW'(r_w - 1'b1);
        if (r_hgt == '0)
            h_m1 = '0;
        else if (r_hgt > hnm_pkg::CFG_HGT_W'(hnm_pkg::MAX_HEIGHT))
            h_m1 = hnm_pkg::ROW_W'(hnm_pkg::MAX_HEIGHT - 1);
        else
            h_m1 = hnm_pkg::ROW_W'(r_hgt - 1'b1);
        last_col = r_col >= w_m1;
        last_row = r_row >= h_m1;
    end

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_load = (r_state == hnm_pkg::ST_PUSH) && (!r_out_valid || o_out.ready);

    assign i_in.ready  = (r_state == hnm_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign ram_raddr = (r_state == hnm_pkg::ST_IDLE) ? r_col : AW'(r_col + 1'b1);

    hnm_line_ram #(
        .DEPTH(hnm_pkg::MAX_WIDTH),
        .WIDTH(8)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == hnm_pkg::ST_WR),
        .i_waddr (r_col),
        .i_wdata (r_h),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // lowest pending job first
    always_comb begin
        sel    = hnm_pkg::JOB_UP;
        n_mask = r_mask;
        priority if (r_mask[0]) begin
            sel       = hnm_pkg::JOB_UP;
            n_mask[0] = 1'b0;
        end else if (r_mask[1]) begin
            sel       = hnm_pkg::JOB_LEFT;
            n_mask[1] = 1'b0;
        end else if (r_mask[2]) begin
            sel       = hnm_pkg::JOB_LAST;
            n_mask[2] = 1'b0;
        end
    end

    always_comb begin
        req.start = (r_state == hnm_pkg::ST_JOB) && (r_mask != '0);
        unique case (sel)
            hnm_pkg::JOB_UP: begin
                req.h = r_up;   req.right = r_right; req.below = r_h;
            end
            hnm_pkg::JOB_LEFT: begin
                req.h = r_left; req.right = r_h;     req.below = r_left;
            end
            default: begin
                req.h = r_h;    req.right = r_h;     req.below = r_h;
            end
        endcase
    end

    hnm_norm_unit u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hnm_pkg::ST_IDLE:     if (in_acc) n_state = hnm_pkg::ST_RD_RIGHT;
            hnm_pkg::ST_RD_RIGHT: n_state = hnm_pkg::ST_WR;
            hnm_pkg::ST_WR:       n_state = hnm_pkg::ST_JOB;
            hnm_pkg::ST_JOB: begin
                n_state = (r_mask == '0) ? hnm_pkg::ST_FINISH : hnm_pkg::ST_WAIT;
            end
            hnm_pkg::ST_WAIT:     if (rsp.done) n_state = hnm_pkg::ST_PUSH;
            hnm_pkg::ST_PUSH:     if (out_load) n_state = hnm_pkg::ST_JOB;
            hnm_pkg::ST_FINISH:   n_state = hnm_pkg::ST_IDLE;
            default:              n_state = hnm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hnm_pkg::ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_w         <= hnm_pkg::WIDTH_RESET;
            r_hgt       <= hnm_pkg::HEIGHT_RESET;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
        end else begin
            r_state <= n_state;
            if (out_load)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;

            if (r_state == hnm_pkg::ST_WR) begin
                r_mask <= {last_row && last_col, last_row && (r_col != '0),
                           r_row != '0};
            end else if (r_state == hnm_pkg::ST_JOB) begin
                r_mask <= n_mask;
            end

            if (r_state == hnm_pkg::ST_FINISH) begin
                r_left <= r_h;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end

            if (cfg_acc) begin
                if (i_cfg.data.index == hnm_pkg::REG_IMAGE_WIDTH) begin
                    r_w   <= i_cfg.data.wdata[hnm_pkg::CFG_WID_W-1:0];
                    r_col <= '0;
                    r_row <= '0;
                end else if (i_cfg.data.index == hnm_pkg::REG_IMAGE_HEIGHT) begin
                    r_hgt <= i_cfg.data.wdata;
                    r_col <= '0;
                    r_row <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_h <= i_in.data.height;
        if (r_state == hnm_pkg::ST_RD_RIGHT)
            r_up <= ram_rdata;
        if (r_state == hnm_pkg::ST_WR)
            r_right <= last_col ? r_up : ram_rdata;
        if (r_state == hnm_pkg::ST_JOB) begin
            r_cur      <= sel;
            r_cur_last <= (n_mask == '0);
        end
        if (out_load) begin
            r_out.red         <= rsp.red;
            r_out.green       <= rsp.green;
            r_out.blue        <= rsp.blue;
            r_out.alpha       <= hnm_pkg::ALPHA;
            r_out.last_of_run <= r_cur_last;
            unique case (r_cur)
                hnm_pkg::JOB_UP: begin
                    r_out.out_column   <= hnm_pkg::COL_W'(r_col);
                    r_out.out_row      <= r_row - 1'b1;
                    r_out.end_of_frame <= 1'b0;
                end
                hnm_pkg::JOB_LEFT: begin
                    r_out.out_column   <= hnm_pkg::COL_W'(r_col - 1'b1);
                    r_out.out_row      <= r_row;
                    r_out.end_of_frame <= 1'b0;
                end
                default: begin
                    r_out.out_column   <= hnm_pkg::COL_W'(r_col);
                    r_out.out_row      <= r_row;
                    r_out.end_of_frame <= 1'b1;
                end
            endcase
        end
    end

    `HNM_ASSERT_NEXT(a_accept_reads, in_acc, r_state == hnm_pkg::ST_RD_RIGHT,
        "accepted height did not start the line store read")
    `HNM_ASSERT_NOW(a_start_idle, req.start, !rsp.busy,
        "normal unit started while busy")
    `HNM_ASSERT_NOW(a_done_waiting, rsp.done, r_state == hnm_pkg::ST_WAIT,
        "normal unit finished outside the wait state")
endmodule

FILE: verif/hnm_checker.sv
`timescale 1ns / 1ps
// Normal map checker: watches the config, height and normal channels, predicts each pixel.
// Depends on hnm_pkg and the channel interfaces in hnm_if.
module hnm_checker
    import hnm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hnm_in_if    in_ch,
    hnm_out_if   out_ch,
    hnm_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_outstanding
);

    logic [7:0]           line_store [MAX_WIDTH];
    logic [COL_W-1:0]     col_cnt;
    logic [ROW_W-1:0]     row_cnt;
    logic [7:0]           left_h;
    logic [CFG_WID_W-1:0] width_reg;
    logic [CFG_HGT_W-1:0] height_reg;
    t_out_data            pixels_due [$];

    function automatic int unsigned root_floor(input int unsigned v);
        int unsigned r;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            if ((r | (32'd1 << b)) * (r | (32'd1 << b)) <= v)
                r = r | (32'd1 << b);
        end
        return r;
    endfunction

    // floor(128*d/sqrt(s)), exact
    function automatic int slope_term(input int d, input int unsigned s);
        int unsigned m, a, q;
        m = (d < 0) ? -d : d;
        a = 16384 * m * m;
        q = root_floor(a / s);
        if (d >= 0)
            return q;
        if (longint'(q) * q * s != longint'(a))
            q++;
        return -int'(q);
    endfunction

    function automatic t_out_data normal_px(input int h, input int right, input int below,
                                            input int col, input int row, input logic eof);
        t_out_data   px;
        int          dx, dy;
        int unsigned s, b;
        dx = h - right;
        dy = h - below;
        s = dx * dx + dy * dy + 65025;
        b = 128 + root_floor(32'd1065369600 / s);
        px.red          = 8'(128 + slope_term(dx, s));
        px.green        = 8'(128 + slope_term(-dy, s));
        px.blue         = (b > 255) ? 8'd255 : 8'(b);
        px.alpha        = 8'd255;
        px.out_column   = COL_W'(col);
        px.out_row      = ROW_W'(row);
        px.last_of_run  = 1'b0;
        px.end_of_frame = eof;
        return px;
    endfunction

    task automatic predict_height(input logic [7:0] h);
        int        w, hg;
        logic      last_col, last_row;
        int        up, right;
        t_out_data run [$];
        w  = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        hg = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        last_col = col_cnt >= w - 1;
        last_row = row_cnt >= hg - 1;
        if (row_cnt >= 1) begin
            up = line_store[col_cnt];
            right = up;
            if (!last_col && col_cnt + 1 < MAX_WIDTH)
                right = line_store[col_cnt + 1];
            run.push_back(normal_px(up, right, h, col_cnt, row_cnt - 1, 1'b0));
        end
        line_store[col_cnt] = h;
        if (last_row) begin
            if (col_cnt >= 1)
                run.push_back(normal_px(left_h, h, left_h, col_cnt - 1, row_cnt, 1'b0));
            if (last_col)
                run.push_back(normal_px(h, h, h, col_cnt, row_cnt, 1'b1));
        end
        left_h = h;
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        if (run.size() > 0)
            run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i])
            pixels_due.push_back(run[i]);
    endtask

    task automatic compare_px(input t_out_data got);
        t_out_data want;
        if (pixels_due.size() == 0) begin
            $error("unexpected normal pixel col %0d row %0d", got.out_column, got.out_row);
            o_fail_count++;
            return;
        end
        want = pixels_due.pop_front();
        if (got.red != want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            o_fail_count++;
        end
        if (got.green != want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            o_fail_count++;
        end
        if (got.blue != want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            o_fail_count++;
        end
        if (got.alpha != want.alpha) begin
            $error("alpha: expected %0d, got %0d", want.alpha, got.alpha);
            o_fail_count++;
        end
        if (got.out_column != want.out_column) begin
            $error("out_column: expected %0d, got %0d", want.out_column, got.out_column);
            o_fail_count++;
        end
        if (got.out_row != want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
            o_fail_count++;
        end
        if (got.last_of_run != want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            o_fail_count++;
        end
        if (got.end_of_frame != want.end_of_frame) begin
            $error("end_of_frame: expected %0b, got %0b", want.end_of_frame,
                   got.end_of_frame);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            col_cnt    = '0;
            row_cnt    = '0;
            left_h     = '0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            pixels_due.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.data.index == REG_IMAGE_WIDTH) begin
                    width_reg = cfg_ch.data.wdata[CFG_WID_W-1:0];
                    col_cnt = '0;
                    row_cnt = '0;
                end else if (cfg_ch.data.index == REG_IMAGE_HEIGHT) begin
                    height_reg = cfg_ch.data.wdata;
                    col_cnt = '0;
                    row_cnt = '0;
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_height(in_ch.data.height);
            if (out_ch.valid && out_ch.ready)
                compare_px(out_ch.data);
        end
        o_outstanding = pixels_due.size();
    end

endmodule

FILE: verif/tb_height_to_normal_map_top.sv
`timescale 1ns / 1ps
// Testbench top of the normal map block: clock, reset, config, height stimulus and verdict.
// Depends on hnm_pkg, hnm_if, hnm_checker and the block itself.
module tb_height_to_normal_map_top;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   burst_left;
    int   stall_mode = 0;
    int   stall_left = 0;
    int   random_sent;
    int   last_h;

    hnm_in_if  in_ch ();
    hnm_out_if out_ch ();
    hnm_cfg_if cfg_ch ();

    height_to_normal_map_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hnm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_ch        (cfg_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver: alternates between always ready, random ready and long stalls
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // stop sending, then wait until every predicted pixel has come out
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [hnm_pkg::CFG_IDX_W-1:0] idx, input int value);
        drain_and_settle();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.wdata <= value[hnm_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_height(input logic [7:0] h, input logic no_gaps);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.data.height <= h;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    function automatic logic [7:0] pick_height(input int style);
        int v;
        case (style)
            0: v = $urandom_range(0, 255);
            1: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
            default: begin
                v = last_h + int'($urandom_range(0, 16)) - 8;
                v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
            end
        endcase
        last_h = v;
        return 8'(v);
    endfunction

    initial begin
        int w, hg, n, style;
        logic calm;
        logic [7:0] slope_pat [9];
        logic [7:0] column_pat [4];
        slope_pat  = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128};
        column_pat = '{8'd255, 8'd0, 8'd200, 8'd1};
        in_ch.valid       <= 1'b0;
        in_ch.data        <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        burst_left        = 0;
        random_sent       = 0;
        last_h            = 128;
        i_rst_n           <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small frame with extreme slopes in both directions
        cfg_write(hnm_pkg::REG_IMAGE_WIDTH, 3);
        cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, 3);
        foreach (slope_pat[i])
            send_height(slope_pat[i], 1'b0);
        // single pixel frame, then zero sizes which act as one
        cfg_write(hnm_pkg::REG_IMAGE_WIDTH, 1);
        cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, 1);
        send_height(8'd0, 1'b0);
        send_height(8'd255, 1'b0);
        cfg_write(hnm_pkg::REG_IMAGE_WIDTH, 0);
        cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, 0);
        send_height(8'd77, 1'b0);
        // single column, several rows
        cfg_write(hnm_pkg::REG_IMAGE_WIDTH, 1);
        cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, 4);
        foreach (column_pat[i])
            send_height(column_pat[i], 1'b0);

        // oversize width on a single row, partly fed
        cfg_write(hnm_pkg::REG_IMAGE_WIDTH, 4095);
        cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, 1);
        for (int i = 0; i < 16; i++)
            send_height(pick_height(i % 3), 1'b0);
        // tallest frame setting, only part of the first row fed, then restarted
        cfg_write(hnm_pkg::REG_IMAGE_WIDTH, hnm_pkg::MAX_WIDTH);
        cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, 8191);
        for (int i = 0; i < 40; i++)
            send_height(pick_height(0), 1'b0);
        cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, hnm_pkg::MAX_HEIGHT);
        for (int i = 0; i < 8; i++)
            send_height(pick_height(0), 1'b0);

        while (random_sent < 420) begin
            w  = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            hg = $urandom_range(1, 5);
            if ($urandom_range(0, 1) != 0) begin
                cfg_write(hnm_pkg::REG_IMAGE_WIDTH, w);
                cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, hg);
            end else begin
                cfg_write(hnm_pkg::REG_IMAGE_HEIGHT, hg);
                cfg_write(hnm_pkg::REG_IMAGE_WIDTH, w);
            end
            n = w * hg;
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(1, n);
            style = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++) begin
                send_height(pick_height(style), calm);
                random_sent++;
            end
        end

        drain_and_settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/hnm_pkg.sv
hw/rtl/hnm_if.sv
hw/rtl/hnm_line_ram.sv
hw/rtl/hnm_norm_unit.sv
hw/rtl/height_to_normal_map_top.sv
verif/hnm_checker.sv
verif/tb_height_to_normal_map_top.sv
